// ===== design/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and codes of the RPN stack calculator
// Command codes, status codes and the controller state type.
// ----------------------------------------------------------------------------
package rpn_pkg;

    typedef enum logic [3:0] {
        CMD_PUSH   = 4'd0,
        CMD_ADD    = 4'd1,
        CMD_SUB    = 4'd2,
        CMD_MUL    = 4'd3,
        CMD_DIV    = 4'd4,
        CMD_MOD    = 4'd5,
        CMD_PEEK   = 4'd6,
        CMD_DUP    = 4'd7,
        CMD_SWAP   = 4'd8,
        CMD_CLEAR  = 4'd9,
        CMD_ASSIGN = 4'd10,
        CMD_RECALL = 4'd11,
        CMD_EMIT   = 4'd12
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_ZERO_DIV  = 3'd3,
        ST_BAD_VAR   = 3'd4,
        ST_BAD_CMD   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,     // read top entry issued
        S_RD2,     // read second entry issued
        S_VAR,     // variable read data present
        S_EXEC,    // operands present, start work
        S_MUL1,
        S_MUL2,
        S_DIVW,
        S_WB,      // write back result
        S_WB2,     // second write of swap
        S_OUT
    } state_t;

    localparam int NUM_VARS_C  = 26;
    localparam int CODE_FIRST  = 65;
    localparam int CODE_LAST   = 90;

    // divider request / response bundle
    typedef struct packed {
        logic        start;
        logic        is_mod;
        logic [63:0] num_mag;
        logic [63:0] den_mag;
    } div_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] quot;
        logic [63:0]  rem;
    } div_rsp_t;

endpackage

// ===== design/rpn_divider.sv =====
// ----------------------------------------------------------------------------
// rpn_divider: shared restoring divider, one quotient bit per cycle
// Divides (num << FRAC_BITS) for div or num for mod by an unsigned divisor.
// ----------------------------------------------------------------------------
module rpn_divider
    import rpn_pkg::*;
#(
    parameter int FRAC_BITS = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [127:0] num_reg, num_next;
    logic [127:0] quot_reg, quot_next;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  den_reg, den_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [64:0]  shifted;
    logic [64:0]  diff;

    always_comb
    begin
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, num_reg[127]};
        diff      = shifted - {1'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            den_next  = req.den_mag;
            rem_next  = '0;
            quot_next = '0;
            if (req.is_mod)
            begin
                num_next = {req.num_mag, 64'd0};
                cnt_next = 8'd64;
            end
            else
            begin
                num_next = {64'd0, req.num_mag} << FRAC_BITS;
                cnt_next = 8'd128;
            end
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[126:0], 1'b0};
            if (!diff[64])
            begin
                rem_next  = diff[63:0];
                quot_next = {quot_reg[126:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[63:0];
                quot_next = {quot_reg[126:0], 1'b0};
            end
            cnt_next = cnt_reg - 8'd1;
            if (cnt_reg == 8'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== design/rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator: RPN stack calculator on Q31.32 fixed point
// Command sequencer around a stack memory and a variable memory.
// ----------------------------------------------------------------------------
// Use: s_axis carries one command beat (cmd, operand_value, var_select);
// m_axis returns exactly one result beat per command (result_value,
// value_valid, status). One command is worked on at a time: s_tready is
// high only while the sequencer is idle.
// Path from acceptance: clear runs S_RD1, S_OUT; push adds S_WB; peek and
// emit add S_RD2; recall adds S_VAR, S_WB; dup adds S_RD2, S_WB; swap adds
// S_RD2, S_EXEC, S_WB2; add, sub and assign add S_RD2, S_EXEC, S_MUL1, S_WB;
// mul also S_MUL2 (two product stages); mod and div wait in S_DIVW on the
// shared one-bit-per-cycle divider (64 and 128 steps). With the receiver
// ready, the sequencer is back in idle as the result appears.
// The stack sits in a synchronous memory; each pop is a registered read,
// so two-operand commands take two reads.
// Reset clears the stack count, the output valid and the variable valid
// bits (variables read as zero until written); stack contents stay undefined.
// When the receiver stalls, the result beat waits in the output register;
// the next command is still taken and runs, and its result waits in the
// sequencer until the output register is free.
// ----------------------------------------------------------------------------
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 128,
    parameter int FRAC_BITS   = 32,
    parameter int NUM_VARS    = 26
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] cmd, [67:4] operand_value, [72:68] var_select, [79:73] zero
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [63:0] result_value, [64] value_valid, [67:65] status, [71:68] zero
    output logic [71:0] m_tdata
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int VW = $clog2(NUM_VARS);
    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;

    // memories
    logic [63:0] stack_mem [STACK_DEPTH];
    logic [63:0] var_mem [NUM_VARS];
    logic [NUM_VARS-1:0] var_vld_reg;

    state_t state_reg, state_next;
    logic [7:0]  cnt_reg, cnt_next;
    cmd_t        cmd_reg;
    logic [63:0] opv_reg;
    logic [4:0]  vsel_reg;
    logic [63:0] r_reg, r_next;
    logic [63:0] l_reg, l_next;
    logic [63:0] res_reg, res_next;
    logic [2:0]  st_reg, st_next;
    logic        vv_reg, vv_next;
    logic        m_tvalid_reg;
    logic [67:0] out_data_reg;
    logic        out_load;

    // stack port
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic          var_rd_en;
    logic [VW-1:0] var_rd_addr;
    logic [63:0]   var_rd_reg;
    logic          var_rd_vld_reg;
    logic          var_wr_en;
    logic [VW-1:0] var_wr_addr;

    // multiplier partial products
    logic [63:0] px_reg, py_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] prod;
    logic        neg_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    rpn_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp)
    );

    function automatic logic [63:0] magn(input logic [63:0] v);
        magn = v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] sat_mag(input logic [127:0] m, input logic neg);
        if (neg)
            sat_mag = (m[127:64] != 0 || m[63:0] > SIGN64) ? SIGN64 : (64'd0 - m[63:0]);
        else
            sat_mag = (m[127:64] != 0 || m[63:0] > MAX64) ? MAX64 : m[63:0];
    endfunction

    // input capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd_t'(s_tdata[3:0]);
            opv_reg     <= s_tdata[67:4];
            vsel_reg    <= s_tdata[72:68];
        end
    end

    // stack memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= stack_mem[rd_addr];
    end

    // variable memory with valid bits
    always_ff @(posedge clk)
    begin
        if (var_wr_en)
            var_mem[var_wr_addr] <= r_reg;
        if (var_rd_en)
        begin
            var_rd_reg     <= var_mem[var_rd_addr];
            var_rd_vld_reg <= var_vld_reg[var_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            var_vld_reg <= '0;
        else if (var_wr_en)
            var_vld_reg[var_wr_addr] <= 1'b1;
    end

    // multiplier stages: 32x32 partial products, then sum
    always_ff @(posedge clk)
    begin
        p00_reg <= px_reg[31:0]  * py_reg[31:0];
        p01_reg <= px_reg[31:0]  * py_reg[63:32];
        p10_reg <= px_reg[63:32] * py_reg[31:0];
        p11_reg <= px_reg[63:32] * py_reg[63:32];
    end
    assign prod = {p11_reg, 64'd0} + {32'd0, p01_reg, 32'd0}
                + {32'd0, p10_reg, 32'd0} + {64'd0, p00_reg};

    // assign code check
    logic        code_ok;
    logic [63:0] code_ip;
    assign code_ip = l_reg >>> FRAC_BITS;
    assign code_ok = !l_reg[63] && code_ip >= 64'(CODE_FIRST) && code_ip <= 64'(CODE_LAST);

    logic [63:0] add_r, sub_r;
    assign add_r = l_reg + r_reg;
    assign sub_r = l_reg - r_reg;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        r_next      = r_reg;
        l_next      = l_reg;
        res_next    = res_reg;
        st_next     = st_reg;
        vv_next     = vv_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = r_reg;
        var_rd_en   = 1'b0;
        var_rd_addr = vsel_reg[VW-1:0];
        var_wr_en   = 1'b0;
        var_wr_addr = VW'(code_ip - 64'(CODE_FIRST));
        dreq.start   = 1'b0;
        dreq.is_mod  = (cmd_reg == CMD_MOD);
        dreq.num_mag = magn(l_reg);
        dreq.den_mag = magn(r_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    st_next  = ST_OK;
                    vv_next  = 1'b0;
                    res_next = '0;
                    r_next   = '0;
                    l_next   = '0;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                // issue read of top entry
                rd_en   = 1'b1;
                rd_addr = AW'(cnt_reg - 8'd1);
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        r_next = opv_reg;
                        state_next = S_WB;
                    end
                    CMD_CLEAR:
                    begin
                        cnt_next = '0;
                        state_next = S_OUT;
                    end
                    CMD_RECALL:
                    begin
                        if (vsel_reg < 5'(NUM_VARS))
                        begin
                            var_rd_en  = 1'b1;
                            state_next = S_VAR;
                        end
                        else
                        begin
                            st_next = ST_BAD_VAR;
                            state_next = S_OUT;
                        end
                    end
                    CMD_PEEK, CMD_DUP:
                    begin
                        state_next = (cnt_reg != 0) ? S_RD2 : S_OUT;
                        vv_next    = (cmd_reg == CMD_PEEK);
                        if (cmd_reg == CMD_DUP && cnt_reg == 8'(STACK_DEPTH))
                            state_next = S_OUT;
                    end
                    CMD_SWAP:
                        state_next = (cnt_reg >= 8'd2) ? S_RD2 : S_OUT;
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_ASSIGN, CMD_EMIT:
                    begin
                        if (cnt_reg != 0)
                        begin
                            cnt_next = cnt_reg - 8'd1;
                            state_next = S_RD2;
                        end
                        else
                        begin
                            st_next = ST_EMPTY;
                            r_next = '0;
                            state_next = S_RD2;
                        end
                    end
                    default:
                    begin
                        st_next = ST_BAD_CMD;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_RD2:
            begin
                // top data valid if stack was nonempty
                rd_en   = 1'b1;
                rd_addr = AW'(cnt_reg - 8'd1);
                state_next = S_EXEC;
                case (cmd_reg)
                    CMD_PEEK:
                    begin
                        res_next = rd_data_reg;
                        state_next = S_OUT;
                    end
                    CMD_DUP:
                    begin
                        r_next = rd_data_reg;
                        state_next = S_WB;
                    end
                    CMD_SWAP:
                    begin
                        r_next = rd_data_reg;
                        rd_addr = AW'(cnt_reg - 8'd2);
                    end
                    CMD_EMIT:
                    begin
                        vv_next  = 1'b1;
                        res_next = (st_reg == ST_EMPTY) ? 64'd0 : rd_data_reg;
                        state_next = S_OUT;
                    end
                    CMD_DIV:
                    begin
                        r_next = (st_reg == ST_EMPTY) ? 64'd0 : rd_data_reg;
                        if (((st_reg == ST_EMPTY) ? 64'd0 : rd_data_reg) == 64'd0)
                        begin
                            if (st_reg == ST_OK)
                                st_next = ST_ZERO_DIV;
                            state_next = S_OUT;
                        end
                        else if (cnt_reg != 0)
                            cnt_next = cnt_reg - 8'd1;
                        else if (st_reg == ST_OK)
                            st_next = ST_EMPTY;
                    end
                    default:
                    begin
                        // second pop
                        r_next = (st_reg == ST_EMPTY) ? 64'd0 : rd_data_reg;
                        if (cnt_reg != 0)
                            cnt_next = cnt_reg - 8'd1;
                        else if (st_reg == ST_OK)
                            st_next = ST_EMPTY;
                    end
                endcase
            end
            S_EXEC:
            begin
                // second entry valid now; the register zeroes it if its pop hit empty
                l_next = rd_data_reg;
                state_next = S_MUL1;
                case (cmd_reg)
                    CMD_SWAP:
                    begin
                        // write old second to top, old top to second
                        wr_en   = 1'b1;
                        wr_addr = AW'(cnt_reg - 8'd1);
                        wr_data = rd_data_reg;
                        state_next = S_WB2;
                    end
                    default:
                        state_next = S_MUL1;
                endcase
            end
            S_MUL1:
            begin
                // both operands settled: arithmetic, divider start or variable write
                state_next = S_OUT;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        r_next = (!(l_reg[63] ^ r_reg[63]) && (add_r[63] ^ l_reg[63]))
                               ? (l_reg[63] ? SIGN64 : MAX64) : add_r;
                        state_next = S_WB;
                    end
                    CMD_SUB:
                    begin
                        r_next = ((l_reg[63] ^ r_reg[63]) && (sub_r[63] ^ l_reg[63]))
                               ? (l_reg[63] ? SIGN64 : MAX64) : sub_r;
                        state_next = S_WB;
                    end
                    CMD_MUL:
                    begin
                        cnt_next = cnt_reg;
                        state_next = S_MUL2;
                    end
                    CMD_DIV:
                    begin
                        dreq.start = 1'b1;
                        state_next = S_DIVW;
                    end
                    CMD_MOD:
                    begin
                        if (r_reg == 64'd0)
                        begin
                            if (st_reg == ST_OK)
                                st_next = ST_ZERO_DIV;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            dreq.start = 1'b1;
                            state_next = S_DIVW;
                        end
                    end
                    CMD_ASSIGN:
                    begin
                        if (code_ok)
                        begin
                            var_wr_en = 1'b1;
                            state_next = S_WB;
                        end
                        else
                        begin
                            if (st_reg == ST_OK)
                                st_next = ST_BAD_VAR;
                            state_next = S_OUT;
                        end
                    end
                    default:
                        state_next = S_OUT;
                endcase
            end
            S_MUL2:
            begin
                // products from px/py registered last cycle
                if (vv_reg)
                begin
                    r_next = sat_mag(prod >> FRAC_BITS, neg_reg);
                    vv_next = 1'b0;
                    state_next = S_WB;
                end
                else
                    vv_next = 1'b1;
            end
            S_DIVW:
            begin
                if (drsp.done)
                begin
                    if (cmd_reg == CMD_MOD)
                        r_next = l_reg[63] ? (64'd0 - drsp.rem) : drsp.rem;
                    else
                        r_next = sat_mag(drsp.quot, l_reg[63] ^ r_reg[63]);
                    state_next = S_WB;
                end
            end
            S_VAR:
            begin
                r_next = var_rd_vld_reg ? var_rd_reg : 64'd0;
                state_next = S_WB;
            end
            S_WB:
            begin
                if (cnt_reg < 8'(STACK_DEPTH))
                begin
                    wr_en    = 1'b1;
                    wr_addr  = AW'(cnt_reg);
                    wr_data  = r_reg;
                    cnt_next = cnt_reg + 8'd1;
                end
                else if (st_reg == ST_OK)
                    st_next = ST_FULL;
                state_next = S_OUT;
            end
            S_WB2:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(cnt_reg - 8'd2);
                wr_data = r_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hand the beat over once the output register is free
                if (!m_tvalid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // left operand zeroing for empty second pop, and multiplier operands
    logic l_empty_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD2)
            l_empty_reg <= (cnt_reg == 0);
        if (state_reg == S_MUL1)
        begin
            px_reg  <= magn(l_reg);
            py_reg  <= magn(r_reg);
            neg_reg <= l_reg[63] ^ r_reg[63];
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        res_reg <= res_next;
        if (state_reg == S_EXEC && cmd_reg != CMD_SWAP && l_empty_reg)
            l_reg <= 64'd0;
        else
            l_reg <= l_next;
    end

    // output register loads the finished beat when empty or being drained
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= {st_reg, vv_reg, res_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            st_reg       <= ST_OK;
            vv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            st_reg    <= st_next;
            vv_reg    <= vv_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

`ifndef SYNTH
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("ready while busy");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 8'(STACK_DEPTH))
        else $error("stack count overflow");
    a_idle_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == S_IDLE && m_tvalid))
        else $error("sequencer not idle after output load");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the RPN stack calculator
// Runs a short directed table of commands, then random command streams.
// Streams are push-heavy, drain-heavy, assign sequences or a mix of these.
// An in-bench model predicts each result beat, except that typed directed
// rows give their own. Results are compared field by field, in order. The
// sender works in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb
    import rpn_pkg::*;
();

    localparam int DEPTH       = 128;
    localparam int FRAC        = 32;
    localparam int NVARS       = 26;
    localparam int ITEMS       = 1300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [63:0] MAXV = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE  = 64'h1_0000_0000;

    typedef struct {
        logic [63:0] value;
        logic        vv;
        logic [2:0]  st;
    } result_t;

    typedef struct {
        cmd_t        cmd;
        logic [63:0] val;
        logic [4:0]  vsel;
        bit          typed;
        result_t     res;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    // model state
    logic [63:0] calc_stack [DEPTH];
    int          calc_depth;
    logic [63:0] calc_vars [NVARS];

    result_t     pending_results[$];
    row_t        dir_rows[$];
    int          errors;
    int          n_sent;
    int          n_checked;
    int          n_full;
    int          n_empty;
    int          n_zdiv;
    longint      cycles;
    int          burst_left;

    rpn_stack_calculator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report(input string msg);
        $display("tb: mismatch: %s", msg);
        errors++;
    endtask

    // ---------------- model ----------------
    function automatic logic [63:0] stack_pop(inout logic [2:0] st);
        if (calc_depth > 0)
        begin
            calc_depth--;
            return calc_stack[calc_depth];
        end
        if (st == ST_OK) st = ST_EMPTY;
        return '0;
    endfunction

    function automatic void stack_push(input logic [63:0] v, inout logic [2:0] st);
        if (calc_depth < DEPTH)
        begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
        else if (st == ST_OK)
            st = ST_FULL;
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] clamp(input logic [127:0] m, input bit neg);
        if (neg)
            return (m[127:64] != 0 || m[63:0] > MINV) ? MINV : -m[63:0];
        return (m[127:64] != 0 || m[63:0] > MAXV) ? MAXV : m[63:0];
    endfunction

    function automatic logic [63:0] add_clamp(input logic [63:0] a, b, input bit sub);
        logic [63:0] r;
        logic [63:0] bb;
        bb = sub ? ~b : b;
        r = sub ? a - b : a + b;
        if (a[63] == bb[63] && r[63] != a[63])
            return a[63] ? MINV : MAXV;
        return r;
    endfunction

    function automatic result_t calc_step(input logic [3:0] c, input logic [63:0] v,
                                          input logic [4:0] vs);
        result_t     o;
        logic [63:0] l;
        logic [63:0] r;
        logic [127:0] w;
        logic [63:0] code;
        o = '{value: '0, vv: 1'b0, st: ST_OK};
        case (c)
            CMD_PUSH: stack_push(v, o.st);
            CMD_ADD, CMD_SUB:
            begin
                r = stack_pop(o.st);
                l = stack_pop(o.st);
                stack_push(add_clamp(l, r, c == CMD_SUB), o.st);
            end
            CMD_MUL:
            begin
                r = stack_pop(o.st);
                l = stack_pop(o.st);
                w = ({64'b0, mag(l)} * {64'b0, mag(r)}) >> FRAC;
                stack_push(clamp(w, l[63] ^ r[63]), o.st);
            end
            CMD_DIV:
            begin
                r = stack_pop(o.st);
                if (r != 0)
                begin
                    l = stack_pop(o.st);
                    w = ({64'b0, mag(l)} << FRAC) / {64'b0, mag(r)};
                    stack_push(clamp(w, l[63] ^ r[63]), o.st);
                end
                else if (o.st == ST_OK)
                    o.st = ST_ZERO_DIV;
            end
            CMD_MOD:
            begin
                r = stack_pop(o.st);
                l = stack_pop(o.st);
                if (r != 0)
                begin
                    w[63:0] = mag(l) % mag(r);
                    stack_push(l[63] ? -w[63:0] : w[63:0], o.st);
                end
                else if (o.st == ST_OK)
                    o.st = ST_ZERO_DIV;
            end
            CMD_PEEK:
            begin
                o.vv = 1'b1;
                if (calc_depth > 0) o.value = calc_stack[calc_depth - 1];
            end
            CMD_DUP:
                if (calc_depth > 0 && calc_depth < DEPTH)
                begin
                    calc_stack[calc_depth] = calc_stack[calc_depth - 1];
                    calc_depth++;
                end
            CMD_SWAP:
                if (calc_depth >= 2)
                begin
                    l = calc_stack[calc_depth - 1];
                    calc_stack[calc_depth - 1] = calc_stack[calc_depth - 2];
                    calc_stack[calc_depth - 2] = l;
                end
            CMD_CLEAR: calc_depth = 0;
            CMD_ASSIGN:
            begin
                r = stack_pop(o.st);
                code = stack_pop(o.st);
                if (!code[63] && (code >> FRAC) >= CODE_FIRST && (code >> FRAC) <= CODE_LAST)
                begin
                    calc_vars[(code >> FRAC) - CODE_FIRST] = r;
                    stack_push(r, o.st);
                end
                else if (o.st == ST_OK)
                    o.st = ST_BAD_VAR;
            end
            CMD_RECALL:
                if (vs < NVARS) stack_push(calc_vars[vs], o.st);
                else if (o.st == ST_OK) o.st = ST_BAD_VAR;
            CMD_EMIT:
            begin
                o.value = stack_pop(o.st);
                o.vv = 1'b1;
            end
            default: o.st = ST_BAD_CMD;
        endcase
        return o;
    endfunction

    // ---------------- driver ----------------
    task automatic send(input logic [3:0] c, input logic [63:0] v, input logic [4:0] vs,
                        input bit typed, input result_t want);
        result_t got;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, vs, v, c};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        // beat accepted at this edge
        got = calc_step(c, v, vs);
        if (typed)
            pending_results.push_back(want);
        else
            pending_results.push_back(got);
        n_sent++;
        if (got.st == ST_FULL) n_full++;
        if (got.st == ST_EMPTY) n_empty++;
        if (got.st == ST_ZERO_DIV) n_zdiv++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    function automatic logic [63:0] rand_q();
        case ($urandom_range(0, 7))
            0: return {$urandom, $urandom};
            1: return MAXV;
            2: return MINV;
            3: return 64'($signed($urandom_range(0, 40)) - 20) << FRAC;
            4: return {{32{1'b0}}, $urandom};
            5: return -64'({$urandom_range(0, 7), $urandom});
            default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom), $urandom};
        endcase
    endfunction

    function automatic logic [3:0] rand_cmd(input int mode);
        int p;
        p = $urandom_range(0, 99);
        case (mode)
            1: if (p < 85) return CMD_PUSH;
            2: if (p < 50) return CMD_EMIT;
            default: if (p < 35) return CMD_PUSH;
        endcase
        if (p > 96) return 4'($urandom_range(13, 15));
        return 4'($urandom_range(1, 12));
    endfunction

    row_t dr;
    result_t nores;

    task automatic add_row(input cmd_t c, input logic [63:0] v, input logic [4:0] vs,
                           input bit typed, input logic [63:0] rv, input logic vv,
                           input status_t st);
        row_t rw;
        rw.cmd = c;
        rw.val = v;
        rw.vsel = vs;
        rw.typed = typed;
        rw.res = '{value: rv, vv: vv, st: st};
        dir_rows.push_back(rw);
    endtask

    // ---------------- stimulus ----------------
    initial
    begin
        int mode;
        int len;
        nores = '{value: '0, vv: 1'b0, st: ST_OK};
        for (int i = 0; i < NVARS; i++) calc_vars[i] = '0;
        calc_depth = 0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: empty stack, saturation, zero divisor, bad codes
        add_row(CMD_EMIT,   0, 0,  1, 0, 1, ST_EMPTY);
        add_row(CMD_PEEK,   0, 0,  1, 0, 1, ST_OK);
        add_row(CMD_RECALL, 0, 31, 1, 0, 0, ST_BAD_VAR);
        add_row(CMD_RECALL, 0, 25, 1, 0, 0, ST_OK);
        add_row(CMD_CLEAR,  0, 0,  1, 0, 0, ST_OK);
        add_row(CMD_PUSH,   MAXV, 0, 1, 0, 0, ST_OK);
        add_row(CMD_PUSH,   1, 0,  1, 0, 0, ST_OK);
        add_row(CMD_ADD,    0, 0,  1, 0, 0, ST_OK);
        add_row(CMD_EMIT,   0, 0,  1, MAXV, 1, ST_OK);
        add_row(CMD_PUSH,   MINV, 0, 1, 0, 0, ST_OK);
        add_row(CMD_PUSH,   1, 0,  1, 0, 0, ST_OK);
        add_row(CMD_SUB,    0, 0,  1, 0, 0, ST_OK);
        add_row(CMD_EMIT,   0, 0,  1, MINV, 1, ST_OK);
        add_row(CMD_PUSH,   MAXV, 0, 0, 0, 0, ST_OK);
        add_row(CMD_PUSH,   2 * ONE, 0, 0, 0, 0, ST_OK);
        add_row(CMD_MUL,    0, 0,  0, 0, 0, ST_OK);
        add_row(CMD_EMIT,   0, 0,  1, MAXV, 1, ST_OK);
        add_row(CMD_PUSH,   5 * ONE, 0, 0, 0, 0, ST_OK);
        add_row(CMD_PUSH,   0, 0,  0, 0, 0, ST_OK);
        add_row(CMD_DIV,    0, 0,  1, 0, 0, ST_ZERO_DIV);
        add_row(CMD_EMIT,   0, 0,  1, 5 * ONE, 1, ST_OK);
        add_row(CMD_PUSH,   -7, 0, 0, 0, 0, ST_OK);
        add_row(CMD_PUSH,   0, 0,  0, 0, 0, ST_OK);
        add_row(CMD_MOD,    0, 0,  1, 0, 0, ST_ZERO_DIV);
        add_row(CMD_PUSH,   81 * ONE + 7, 0, 0, 0, 0, ST_OK);
        add_row(CMD_PUSH,   -(3 * ONE / 2), 0, 0, 0, 0, ST_OK);
        add_row(CMD_ASSIGN, 0, 0,  0, 0, 0, ST_OK);
        add_row(CMD_RECALL, 0, 16, 0, 0, 0, ST_OK);
        add_row(CMD_DUP,    0, 0,  0, 0, 0, ST_OK);
        add_row(CMD_SWAP,   0, 0,  0, 0, 0, ST_OK);
        add_row(CMD_DIV,    0, 0,  0, 0, 0, ST_OK);
        add_row(CMD_PEEK,   0, 0,  0, 0, 0, ST_OK);
        add_row(cmd_t'(13), 0, 0,  1, 0, 0, ST_BAD_CMD);
        add_row(cmd_t'(15), 0, 0,  1, 0, 0, ST_BAD_CMD);
        foreach (dir_rows[i])
        begin
            dr = dir_rows[i];
            send(dr.cmd, dr.val, dr.vsel, dr.typed, dr.res);
        end

        // random phases: mixed, fill, drain, assign sequences
        while (n_sent < ITEMS)
        begin
            mode = $urandom_range(0, 3);
            len = $urandom_range(20, 160);
            for (int k = 0; k < len && n_sent < ITEMS; k++)
            begin
                if (mode == 3 && $urandom_range(0, 9) != 0)
                begin
                    // code, value, assign, then a recall; sometimes a bad code
                    send(CMD_PUSH, ($urandom_range(0, 4) == 0) ? rand_q()
                         : ({32'($urandom_range(CODE_FIRST, CODE_LAST)), $urandom}),
                         0, 0, nores);
                    send(CMD_PUSH, rand_q(), 0, 0, nores);
                    send(CMD_ASSIGN, rand_q(), 5'($urandom), 0, nores);
                    send(CMD_RECALL, rand_q(), ($urandom_range(0, 7) == 0) ?
                         5'($urandom) : 5'($urandom_range(0, NVARS - 1)), 0, nores);
                end
                else
                    send(rand_cmd(mode), rand_q(), ($urandom_range(0, 7) == 0) ?
                         5'($urandom) : 5'($urandom_range(0, NVARS - 1)), 0, nores);
            end
        end
        s_tvalid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (200) @(posedge clk);
        $display("tb: %0d commands sent, %0d results checked", n_sent, n_checked);
        $display("tb: %0d full pushes, %0d empty pops, %0d zero divisors seen",
                 n_full, n_empty, n_zdiv);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ---------------- receiver stall pattern ----------------
    always @(posedge clk)
    begin
        case ((cycles / 300) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (cycles % 5 == 0);
            default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report("result beat with no command outstanding");
            else
            begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (m_tdata[63:0] !== exp_r.value)
                    report($sformatf("value %h, expected %h", m_tdata[63:0], exp_r.value));
                if (m_tdata[64] !== exp_r.vv)
                    report($sformatf("value_valid %b, expected %b", m_tdata[64], exp_r.vv));
                if (m_tdata[67:65] !== exp_r.st)
                    report($sformatf("status %0d, expected %0d", m_tdata[67:65], exp_r.st));
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial cycles = 0;

endmodule

// ===== sim.f =====
design/rpn_pkg.sv
design/rpn_divider.sv
design/rpn_stack_calculator.sv
sim/tb.sv
